// ===== rtl/falu_pkg.sv =====
// types and constants shared by the fixed-point alu
`default_nettype none

package falu_pkg;

    // command codes
    typedef enum logic [3:0] {
        CMD_ADD     = 4'd0,
        CMD_SUB     = 4'd1,
        CMD_MUL     = 4'd2,
        CMD_DIV     = 4'd3,
        CMD_LT      = 4'd4,
        CMD_GT      = 4'd5,
        CMD_LE      = 4'd6,
        CMD_GE      = 4'd7,
        CMD_EQ      = 4'd8,
        CMD_NE      = 4'd9,
        CMD_MIN     = 4'd10,
        CMD_MAX     = 4'd11,
        CMD_INC     = 4'd12,
        CMD_DEC     = 4'd13,
        CMD_TOINT   = 4'd14,
        CMD_FROMINT = 4'd15
    } cmd_t;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_DIVZERO  = 2'd2;

    localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

    // request transaction
    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } req_t;

    // response transaction
    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic [1:0]         status;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/fixed_point_alu.sv =====
// Pipelined signed fixed-point ALU: add, sub, mul, div, compare, min/max, inc/dec, convert.
// Every command takes the same path: input register, magnitude stage, multiply stage,
// multiply rounding stage, then 33+FRAC_BITS restoring-divider stages (one quotient bit
// each), a divide saturation stage and the output register. One transaction enters per
// cycle while req_stall is low; results leave in order. A two-entry output (register plus
// skid) lets the pipeline keep running after rsp_stall rises until the skid entry is filled;
// req_stall comes from a register.
`default_nettype none

module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire falu_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output falu_pkg::rsp_t      rsp
);

    localparam int DW = 33;               // divisor width (2*|b|)
    localparam int NW = 33 + FRAC_BITS;   // numerator / quotient width
    localparam int PW = 64;               // product width

    typedef struct packed {
        falu_pkg::cmd_t     cmd;
        logic               neg;
        logic signed [31:0] res;
        logic               cmp;
        logic [1:0]         st;
        logic [DW:0]        rem;
        logic [NW-1:0]      nq;
        logic [DW-1:0]      d;
    } dstage_t;

    // saturate a magnitude with sign; returns {status, value}
    function automatic logic [33:0] sat_mag(input logic hi_nz, input logic [31:0] lo,
                                            input logic neg);
        logic [33:0] r;
        begin
            if (neg)
            begin
                if (hi_nz || (lo[31] && (|lo[30:0])))
                    r = {falu_pkg::ST_OVERFLOW, falu_pkg::VAL_MIN};
                else
                    r = {falu_pkg::ST_OK, 32'(-lo)};
            end
            else
            begin
                if (hi_nz || lo[31])
                    r = {falu_pkg::ST_OVERFLOW, falu_pkg::VAL_MAX};
                else
                    r = {falu_pkg::ST_OK, lo};
            end
            return r;
        end
    endfunction

    // stage 0: input register
    logic               v0_reg;
    falu_pkg::cmd_t     c0_reg;
    logic signed [31:0] a0_reg, b0_reg;

    // stage 1: simple ops and magnitudes
    logic               v1_reg;
    falu_pkg::cmd_t     c1_reg;
    logic               neg1_reg;
    logic [31:0]        ma1_reg, mb1_reg;
    logic signed [31:0] res1_reg;
    logic               cmp1_reg;
    logic [1:0]         st1_reg;

    // stage 2: product and divider operands
    logic               v2_reg;
    falu_pkg::cmd_t     c2_reg;
    logic               neg2_reg;
    logic [PW-1:0]      prod2_reg;
    logic [NW-1:0]      n2_reg;
    logic [DW-1:0]      d2_reg;
    logic signed [31:0] res2_reg;
    logic               cmp2_reg;
    logic [1:0]         st2_reg;

    // divider stages; entry 0 is the multiply rounding stage
    logic    dv_vld_reg [0:NW];
    dstage_t dv_reg     [0:NW];

    // final stage
    logic               vf_reg;
    falu_pkg::rsp_t     f_reg;

    // output register and skid
    logic               out_vld_reg, skid_vld_reg;
    falu_pkg::rsp_t     out_reg, skid_reg;

    logic en;
    assign en = !skid_vld_reg;
    assign req_stall = !en;

    // stage 1 logic
    logic signed [32:0] s1_sum, s1_dif, s1_inc, s1_dec;
    logic signed [31:0] s1_res;
    logic               s1_cmp;
    logic [1:0]         s1_st;
    logic [FRAC_BITS:0] s1_top;

    always_comb
    begin
        s1_sum = 33'(a0_reg) + 33'(b0_reg);
        s1_dif = 33'(a0_reg) - 33'(b0_reg);
        s1_inc = 33'(a0_reg) + 33'sd1;
        s1_dec = 33'(a0_reg) - 33'sd1;
        s1_top = a0_reg[31 -: FRAC_BITS + 1];
        s1_res = '0;
        s1_cmp = 1'b0;
        s1_st  = falu_pkg::ST_OK;
        unique case (c0_reg)
            falu_pkg::CMD_ADD:
            begin
                s1_res = s1_sum[31:0];
                if (s1_sum[32] != s1_sum[31])
                begin
                    s1_st  = falu_pkg::ST_OVERFLOW;
                    s1_res = s1_sum[32] ? falu_pkg::VAL_MIN : falu_pkg::VAL_MAX;
                end
            end
            falu_pkg::CMD_SUB:
            begin
                s1_res = s1_dif[31:0];
                if (s1_dif[32] != s1_dif[31])
                begin
                    s1_st  = falu_pkg::ST_OVERFLOW;
                    s1_res = s1_dif[32] ? falu_pkg::VAL_MIN : falu_pkg::VAL_MAX;
                end
            end
            falu_pkg::CMD_MUL: s1_res = '0;
            falu_pkg::CMD_DIV:
            begin
                if (b0_reg == 32'sd0)
                    s1_st = falu_pkg::ST_DIVZERO;
            end
            falu_pkg::CMD_LT:  s1_cmp = a0_reg < b0_reg;
            falu_pkg::CMD_GT:  s1_cmp = a0_reg > b0_reg;
            falu_pkg::CMD_LE:  s1_cmp = a0_reg <= b0_reg;
            falu_pkg::CMD_GE:  s1_cmp = a0_reg >= b0_reg;
            falu_pkg::CMD_EQ:  s1_cmp = a0_reg == b0_reg;
            falu_pkg::CMD_NE:  s1_cmp = a0_reg != b0_reg;
            falu_pkg::CMD_MIN: s1_res = (a0_reg <= b0_reg) ? a0_reg : b0_reg;
            falu_pkg::CMD_MAX: s1_res = (a0_reg >= b0_reg) ? a0_reg : b0_reg;
            falu_pkg::CMD_INC:
            begin
                s1_res = s1_inc[31:0];
                if (s1_inc[32] != s1_inc[31])
                begin
                    s1_st  = falu_pkg::ST_OVERFLOW;
                    s1_res = falu_pkg::VAL_MAX;
                end
            end
            falu_pkg::CMD_DEC:
            begin
                s1_res = s1_dec[31:0];
                if (s1_dec[32] != s1_dec[31])
                begin
                    s1_st  = falu_pkg::ST_OVERFLOW;
                    s1_res = falu_pkg::VAL_MIN;
                end
            end
            falu_pkg::CMD_TOINT: s1_res = a0_reg >>> FRAC_BITS;
            falu_pkg::CMD_FROMINT:
            begin
                s1_res = a0_reg <<< FRAC_BITS;
                if ((s1_top != '0) && (s1_top != '1))
                begin
                    s1_st  = falu_pkg::ST_OVERFLOW;
                    s1_res = a0_reg[31] ? falu_pkg::VAL_MIN : falu_pkg::VAL_MAX;
                end
            end
        endcase
    end

    // multiply rounding
    logic [PW-1:0] m3_round;
    logic [33:0]   m3_sat;
    dstage_t       m3_stage;

    always_comb
    begin
        m3_round = (prod2_reg + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        m3_sat   = sat_mag(|m3_round[PW-1:32], m3_round[31:0], neg2_reg);
        m3_stage.cmd = c2_reg;
        m3_stage.neg = neg2_reg;
        m3_stage.res = res2_reg;
        m3_stage.cmp = cmp2_reg;
        m3_stage.st  = st2_reg;
        m3_stage.rem = '0;
        m3_stage.nq  = n2_reg;
        m3_stage.d   = d2_reg;
        if (c2_reg == falu_pkg::CMD_MUL)
        begin
            m3_stage.res = m3_sat[31:0];
            m3_stage.st  = m3_sat[33:32];
        end
    end

    // front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= req_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            vf_reg <= dv_vld_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg   <= falu_pkg::cmd_t'(req.command);
            a0_reg   <= req.operand_a;
            b0_reg   <= req.operand_b;
            c1_reg   <= c0_reg;
            neg1_reg <= a0_reg[31] ^ b0_reg[31];
            ma1_reg  <= a0_reg[31] ? 32'(-a0_reg) : 32'(a0_reg);
            mb1_reg  <= b0_reg[31] ? 32'(-b0_reg) : 32'(b0_reg);
            res1_reg <= s1_res;
            cmp1_reg <= s1_cmp;
            st1_reg  <= s1_st;
            c2_reg   <= c1_reg;
            neg2_reg <= neg1_reg;
            prod2_reg <= PW'(ma1_reg) * PW'(mb1_reg);
            n2_reg   <= (NW'(ma1_reg) << (FRAC_BITS + 1)) + NW'(mb1_reg);
            d2_reg   <= {mb1_reg, 1'b0};
            res2_reg <= res1_reg;
            cmp2_reg <= cmp1_reg;
            st2_reg  <= st1_reg;
        end
    end

    // divider chain: one quotient bit per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (en)
            dv_vld_reg[0] <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dv_reg[0] <= m3_stage;
    end

    for (genvar k = 0; k < NW; k++)
    begin : g_div
        logic [DW:0] rem_sh;
        logic        ge;
        dstage_t     nxt;

        always_comb
        begin
            rem_sh  = {dv_reg[k].rem[DW-1:0], dv_reg[k].nq[NW-1]};
            ge      = rem_sh >= {1'b0, dv_reg[k].d};
            nxt     = dv_reg[k];
            nxt.rem = ge ? rem_sh - {1'b0, dv_reg[k].d} : rem_sh;
            nxt.nq  = {dv_reg[k].nq[NW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[k+1] <= 1'b0;
            else if (en)
                dv_vld_reg[k+1] <= dv_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dv_reg[k+1] <= nxt;
        end
    end

    // divide saturation and result select
    logic [33:0]    q_sat;
    falu_pkg::rsp_t f_next;

    always_comb
    begin
        q_sat = sat_mag(|dv_reg[NW].nq[NW-1:32], dv_reg[NW].nq[31:0], dv_reg[NW].neg);
        f_next.result_value = dv_reg[NW].res;
        f_next.compare_true = dv_reg[NW].cmp;
        f_next.status       = dv_reg[NW].st;
        if ((dv_reg[NW].cmd == falu_pkg::CMD_DIV) && (dv_reg[NW].st != falu_pkg::ST_DIVZERO))
        begin
            f_next.result_value = q_sat[31:0];
            f_next.status       = q_sat[33:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            f_reg <= f_next;
    end

    // output register with skid
    logic deliver, out_free;
    assign deliver  = en && vf_reg;
    assign out_free = !out_vld_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg  <= skid_vld_reg || deliver;
            skid_vld_reg <= 1'b0;
        end
        else if (deliver)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_reg <= skid_vld_reg ? skid_reg : f_reg;
        else if (deliver)
            skid_reg <= f_reg;
    end

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the fixed-point alu: predicted results checked against the output stream
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 8;
    localparam int LATENCY = FRAC + 39;
    localparam int LIMIT_CYCLES = 400000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    falu_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    falu_pkg::rsp_t rsp;

    falu_pkg::req_t pending_q[$];
    falu_pkg::rsp_t expected_q[$];
    int errors;
    int checked;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_active;
    bit stim_done;
    bit req_taken;

    fixed_point_alu #(.FRAC_BITS(FRAC)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // saturate a wide value to 32 bits
    function automatic logic signed [31:0] clamp32(input logic signed [79:0] v,
                                                   inout logic [1:0] st);
        if (v > 80'sd2147483647)
        begin
            st = falu_pkg::ST_OVERFLOW;
            return falu_pkg::VAL_MAX;
        end
        if (v < -80'sd2147483648)
        begin
            st = falu_pkg::ST_OVERFLOW;
            return falu_pkg::VAL_MIN;
        end
        return v[31:0];
    endfunction

    // expected alu output for one request
    function automatic falu_pkg::rsp_t alu_predict(input falu_pkg::req_t r);
        falu_pkg::rsp_t o;
        logic signed [79:0] a;
        logic signed [79:0] b;
        logic signed [79:0] s;
        logic [79:0] ma;
        logic [79:0] mb;
        logic [79:0] m;
        logic neg;
        logic [1:0] st;
        a = r.operand_a;
        b = r.operand_b;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        st = falu_pkg::ST_OK;
        o = '0;
        case (falu_pkg::cmd_t'(r.command))
            falu_pkg::CMD_ADD: o.result_value = clamp32(a + b, st);
            falu_pkg::CMD_SUB: o.result_value = clamp32(a - b, st);
            falu_pkg::CMD_MUL:
            begin
                m = (ma * mb + (80'd1 << (FRAC - 1))) >> FRAC;
                s = neg ? -$signed(m) : $signed(m);
                o.result_value = clamp32(s, st);
            end
            falu_pkg::CMD_DIV:
            begin
                if (b == 0)
                begin
                    o.result_value = '0;
                    st = falu_pkg::ST_DIVZERO;
                end
                else
                begin
                    m = (2 * (ma << FRAC) + mb) / (2 * mb);
                    s = neg ? -$signed(m) : $signed(m);
                    o.result_value = clamp32(s, st);
                end
            end
            falu_pkg::CMD_LT: o.compare_true = a < b;
            falu_pkg::CMD_GT: o.compare_true = a > b;
            falu_pkg::CMD_LE: o.compare_true = a <= b;
            falu_pkg::CMD_GE: o.compare_true = a >= b;
            falu_pkg::CMD_EQ: o.compare_true = a == b;
            falu_pkg::CMD_NE: o.compare_true = a != b;
            falu_pkg::CMD_MIN: o.result_value = (a <= b) ? r.operand_a : r.operand_b;
            falu_pkg::CMD_MAX: o.result_value = (a >= b) ? r.operand_a : r.operand_b;
            falu_pkg::CMD_INC: o.result_value = clamp32(a + 1, st);
            falu_pkg::CMD_DEC: o.result_value = clamp32(a - 1, st);
            falu_pkg::CMD_TOINT: o.result_value = r.operand_a >>> FRAC;
            default: o.result_value = clamp32(a <<< FRAC, st);
        endcase
        o.status = st;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch %0s: got %h expected %h (result %0d)", what, got, want, checked);
    endtask

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return falu_pkg::VAL_MAX - $urandom_range(0, 2);
            1: return falu_pkg::VAL_MIN + $urandom_range(0, 2);
            2: return $signed($urandom_range(0, 4)) - 2;
            3: return $signed($urandom_range(0, 1 << 16)) - (1 << 15);
            4: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input falu_pkg::cmd_t c, input logic signed [31:0] a,
                             input logic signed [31:0] b);
        falu_pkg::req_t r;
        r.command = c;
        r.operand_a = a;
        r.operand_b = b;
        pending_q.push_back(r);
    endtask

    // driver: offers transactions at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (req_taken)
                    void'(pending_q.pop_front());
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req <= pending_q[0];
                end
                else
                    req_valid <= 1'b0;
            end
            rsp_stall <= hold_active || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // prediction on accepted requests
    always @(posedge clk)
    begin
        req_taken <= rst_n && req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall)
            expected_q.push_back(alu_predict(req));
    end

    // monitor: compare each response with the oldest prediction
    always @(posedge clk)
    begin
        falu_pkg::rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected response", rsp.result_value, '0);
            else
            begin
                e = expected_q.pop_front();
                if (rsp.result_value !== e.result_value)
                    report_mismatch("result_value", rsp.result_value, e.result_value);
                if (rsp.compare_true !== e.compare_true)
                    report_mismatch("compare_true", rsp.compare_true, e.compare_true);
                if (rsp.status !== e.status)
                    report_mismatch("status", rsp.status, e.status);
            end
            checked++;
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        int n;
        hold_active = 1'b0;
        wait (stim_done == 1'b0 && rst_n);
        wait (checked > 100);
        @(negedge clk);
        hold_active = 1'b1;
        for (n = 0; n < 300; n++)
            @(negedge clk);
        hold_active = 1'b0;
    end

    task automatic run_phase(input int idle, input int stall, input int count);
        int i;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (i = 0; i < count; i++)
            push_item(falu_pkg::cmd_t'($urandom_range(0, 15)), rand_operand(),
                      rand_operand());
        wait (pending_q.size() == 0 && !req_valid);
    endtask

    // stimulus
    initial
    begin
        int k;
        errors = 0;
        checked = 0;
        cycle_count = 0;
        stim_done = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every command, saturation, divide by zero, rounding ties
        push_item(falu_pkg::CMD_ADD, falu_pkg::VAL_MAX, 32'sd1);
        push_item(falu_pkg::CMD_ADD, falu_pkg::VAL_MIN, -32'sd1);
        push_item(falu_pkg::CMD_SUB, falu_pkg::VAL_MIN, 32'sd1);
        push_item(falu_pkg::CMD_SUB, falu_pkg::VAL_MAX, falu_pkg::VAL_MIN);
        push_item(falu_pkg::CMD_MUL, falu_pkg::VAL_MIN, falu_pkg::VAL_MIN);
        push_item(falu_pkg::CMD_MUL, 32'sd384, -32'sd1);
        push_item(falu_pkg::CMD_MUL, -32'sd1, 32'sd128);
        push_item(falu_pkg::CMD_DIV, 32'sd256, 32'sd0);
        push_item(falu_pkg::CMD_DIV, falu_pkg::VAL_MIN, -32'sd1);
        push_item(falu_pkg::CMD_DIV, 32'sd1, 32'sd512);
        push_item(falu_pkg::CMD_DIV, -32'sd1, 32'sd512);
        push_item(falu_pkg::CMD_MAX, 32'sd5, 32'sd5);
        push_item(falu_pkg::CMD_MIN, 32'sd5, 32'sd5);
        push_item(falu_pkg::CMD_MAX, falu_pkg::VAL_MIN, falu_pkg::VAL_MAX);
        push_item(falu_pkg::CMD_MIN, falu_pkg::VAL_MIN, falu_pkg::VAL_MAX);
        push_item(falu_pkg::CMD_INC, falu_pkg::VAL_MAX, 32'sd0);
        push_item(falu_pkg::CMD_DEC, falu_pkg::VAL_MIN, 32'sd0);
        push_item(falu_pkg::CMD_TOINT, -32'sd1, 32'sd0);
        push_item(falu_pkg::CMD_TOINT, falu_pkg::VAL_MIN, falu_pkg::VAL_MAX);
        push_item(falu_pkg::CMD_FROMINT, 32'sd8388608, 32'sd0);
        push_item(falu_pkg::CMD_FROMINT, -32'sd8388609, 32'sd0);
        for (k = 4; k <= 9; k++)
            push_item(falu_pkg::cmd_t'(k), 32'sd7, 32'sd7);
        push_item(falu_pkg::CMD_LT, falu_pkg::VAL_MIN, falu_pkg::VAL_MAX);
        wait (pending_q.size() == 0 && !req_valid);

        run_phase(0, 0, 225);
        run_phase(59, 0, 225);
        run_phase(0, 59, 225);
        run_phase(24, 24, 225);
        stim_done = 1'b1;

        wait (expected_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        $display("checked %0d responses over all 16 commands, directed edge cases", checked);
        $display("and random phases with sender gaps, receiver stalls and a long hold-off");
        if (errors == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire

// ===== fixed_point_alu.f =====
rtl/falu_pkg.sv
rtl/fixed_point_alu.sv
tb/tb.sv
